// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, compiled out under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check with reset disable
`define GCC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("gcc assertion failed");

// check with no reset disable
`define GCC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("gcc assertion failed");

`else

`define GCC_ASSERT(lbl, clk, rst, prop)
`define GCC_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== sv/gcc_pkg.sv =====
// ---------------------------------------------------------------------------
// gcc_pkg
// Shared types and constants for the graph connectivity check unit.
// ---------------------------------------------------------------------------
`default_nettype none

package gcc_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int MAX_EDGES_DEF    = 64;

  localparam int COL_W     = 32;   // incidence column width
  localparam int EXT_W     = 64;   // column zero-extended to the widest vertex set
  localparam int CFG_W     = 6;    // vertex_count register width
  localparam int CNT_OUT_W = 6;    // reached_count port width

  localparam logic [CFG_W-1:0] VC_RESET = 6'd32;

  typedef enum logic [1:0] {
    S_LOAD,
    S_READ,
    S_EVAL,
    S_DONE
  } gcc_state_t;

  typedef struct packed {
    logic                 connected;
    logic [CNT_OUT_W-1:0] reached_count;
    logic                 overflow;
  } gcc_res_t;

endpackage

`default_nettype wire

// ===== sv/gcc_ram.sv =====
// ---------------------------------------------------------------------------
// gcc_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module gcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/gcc_col_enc.sv =====
// ---------------------------------------------------------------------------
// gcc_col_enc
// Masks one incidence column to the vertices in use and finds its endpoints.
// ---------------------------------------------------------------------------
`default_nettype none

module gcc_col_enc #(
  parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEF,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int CW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic [gcc_pkg::COL_W-1:0] vertex_mask,
  input  wire logic [CW-1:0]             n_used,
  output logic                           edge_ok,
  output logic      [VW-1:0]             edge_lo,
  output logic      [VW-1:0]             edge_hi
);

  logic [gcc_pkg::EXT_W-1:0] col_ext;
  logic [MAX_VERTICES-1:0]   m;

  assign col_ext = {{(gcc_pkg::EXT_W - gcc_pkg::COL_W){1'b0}}, vertex_mask};

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      m[i] = col_ext[i] && (CW'(i) < n_used);
    end
  end

  always_comb begin
    edge_lo = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (m[i]) begin
        edge_lo = VW'(i);
      end
    end
  end

  always_comb begin
    edge_hi = '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      if (m[i]) begin
        edge_hi = VW'(i);
      end
    end
  end

  // empty and one-vertex columns give lo == hi
  assign edge_ok = (edge_lo != edge_hi);

endmodule

`default_nettype wire

// ===== sv/gcc_reach.sv =====
// ---------------------------------------------------------------------------
// gcc_reach
// Edge store sequencer: loads edges, then sweeps the store one edge at a
// time spreading reach until a full pass changes nothing.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gcc_reach #(
  parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = gcc_pkg::MAX_EDGES_DEF,
  localparam int VW = $clog2(MAX_VERTICES),
  localparam int CW = $clog2(MAX_VERTICES + 1),
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
  localparam int FW = $clog2(MAX_EDGES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CW-1:0]    n_used,
  input  wire logic             col_fire,
  input  wire logic             col_last,
  input  wire logic             edge_ok,
  input  wire logic [VW-1:0]    edge_lo,
  input  wire logic [VW-1:0]    edge_hi,
  output logic                  in_ready,
  output logic                  res_valid,
  input  wire logic             res_take,
  output gcc_pkg::gcc_res_t     res
);

  gcc_pkg::gcc_state_t state, state_next;

  logic [FW-1:0]           fill, fill_next;
  logic [AW-1:0]           k, k_next;
  logic                    changed, changed_next;
  logic [MAX_VERTICES-1:0] reached, reached_next;
  logic [CW-1:0]           count, count_next;
  logic                    ovf, ovf_next;

  logic                    ram_we;
  logic [2*VW-1:0]         rdata;
  logic [VW-1:0]           ea, eb;
  logic                    in_rng, hit, last_k;
  logic                    scanning, cleared;

  gcc_ram #(
    .WIDTH (2 * VW),
    .DEPTH (MAX_EDGES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill[AW-1:0]),
    .wdata ({edge_hi, edge_lo}),
    .raddr (k),
    .rdata (rdata)
  );

  assign ea     = rdata[VW-1:0];
  assign eb     = rdata[2*VW-1:VW];
  assign in_rng = (CW'(ea) < n_used) && (CW'(eb) < n_used);
  assign hit    = in_rng && (reached[ea] != reached[eb]);
  assign last_k = ((FW'(k) + FW'(1)) == fill);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= gcc_pkg::S_LOAD;
      fill    <= '0;
      k       <= '0;
      changed <= 1'b0;
      reached <= MAX_VERTICES'(1);
      count   <= CW'(1);
      ovf     <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      k       <= k_next;
      changed <= changed_next;
      reached <= reached_next;
      count   <= count_next;
      ovf     <= ovf_next;
    end
  end

  always_comb begin
    state_next   = state;
    fill_next    = fill;
    k_next       = k;
    changed_next = changed;
    reached_next = reached;
    count_next   = count;
    ovf_next     = ovf;
    ram_we       = 1'b0;
    in_ready     = (state == gcc_pkg::S_LOAD);
    res_valid    = (state == gcc_pkg::S_DONE);

    unique case (state)
      gcc_pkg::S_LOAD: begin
        if (col_fire) begin
          if (edge_ok) begin
            if (fill < FW'(MAX_EDGES)) begin
              ram_we    = 1'b1;
              fill_next = fill + FW'(1);
            end else begin
              ovf_next = 1'b1;
            end
          end
          if (col_last) begin
            k_next       = '0;
            changed_next = 1'b0;
            if (fill_next == '0) begin
              state_next = gcc_pkg::S_DONE;
            end else begin
              state_next = gcc_pkg::S_READ;
            end
          end
        end
      end
      gcc_pkg::S_READ: begin
        state_next = gcc_pkg::S_EVAL;
      end
      gcc_pkg::S_EVAL: begin
        if (hit) begin
          reached_next[ea] = 1'b1;
          reached_next[eb] = 1'b1;
          count_next       = count + CW'(1);
        end
        if (last_k) begin
          k_next       = '0;
          changed_next = 1'b0;
          if (changed || hit) begin
            state_next = gcc_pkg::S_READ;
          end else begin
            state_next = gcc_pkg::S_DONE;
          end
        end else begin
          k_next       = k + AW'(1);
          changed_next = changed || hit;
          state_next   = gcc_pkg::S_READ;
        end
      end
      gcc_pkg::S_DONE: begin
        if (res_take) begin
          fill_next    = '0;
          reached_next = MAX_VERTICES'(1);
          count_next   = CW'(1);
          ovf_next     = 1'b0;
          state_next   = gcc_pkg::S_LOAD;
        end
      end
      default: begin
        state_next = gcc_pkg::S_LOAD;
      end
    endcase
  end

  // each hit adds exactly one new vertex, so the count tracks the mask
  assign res.connected     = (count == n_used);
  assign res.reached_count = gcc_pkg::CNT_OUT_W'(count);
  assign res.overflow      = ovf;

  assign scanning = (state == gcc_pkg::S_READ) || (state == gcc_pkg::S_EVAL);
  assign cleared  = (fill == '0) && (count == CW'(1)) && !ovf;

  `GCC_ASSERT(a_fill_bound, clk, rst, fill <= FW'(MAX_EDGES))
  `GCC_ASSERT(a_count_bound, clk, rst, (count != '0) && (count <= n_used))
  `GCC_ASSERT(a_scan_index, clk, rst, scanning |-> (FW'(k) < fill))
  `GCC_ASSERT(a_clear_after_result, clk, rst, (res_valid && res_take) |=> cleared)

endmodule

`default_nettype wire

// ===== sv/graph_connectivity_check_unit.sv =====
// Column load: one column per cycle, accepted while the sequencer is loading.
// After the last column: each pass reads (S_READ) then evaluates (S_EVAL)
// each stored edge (RAM, registered read); passes repeat until one adds no vertex.
// Result is held in S_DONE, then registered and held in the output stage.
// Sync reset clears control state, sets vertex_count to 32; store is not cleared.
// ---------------------------------------------------------------------------
// graph_connectivity_check_unit
// Incidence-matrix graph connectivity check: edge columns in, one
// connected / reached_count / overflow result per graph out.
// ---------------------------------------------------------------------------
`default_nettype none

module graph_connectivity_check_unit #(
  parameter int MAX_VERTICES = gcc_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = gcc_pkg::MAX_EDGES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gcc_pkg::CFG_W-1:0]       vertex_count,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [gcc_pkg::COL_W-1:0]       vertex_mask,
  input  wire logic                            last_column,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 connected,
  output logic [gcc_pkg::CNT_OUT_W-1:0]        reached_count,
  output logic                                 overflow
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [gcc_pkg::CFG_W-1:0] vc;
  logic [6:0]                vc7;
  logic [6:0]                n7;
  logic [CW-1:0]             n_used;

  logic                      in_ready;
  logic                      col_fire;
  logic                      edge_ok;
  logic [VW-1:0]             edge_lo, edge_hi;
  logic                      res_valid, res_take;
  gcc_pkg::gcc_res_t         res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= gcc_pkg::VC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vc <= vertex_count;
    end
  end

  assign vc7 = 7'(vc);

  always_comb begin
    priority if (vc7 == 7'd0) begin
      n7 = 7'd1;
    end else if (vc7 > 7'(MAX_VERTICES)) begin
      n7 = 7'(MAX_VERTICES);
    end else begin
      n7 = vc7;
    end
  end

  assign n_used = CW'(n7);

  assign in_stall = !in_ready;
  assign col_fire = in_valid && in_ready;

  gcc_col_enc #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_enc (
    .vertex_mask (vertex_mask),
    .n_used      (n_used),
    .edge_ok     (edge_ok),
    .edge_lo     (edge_lo),
    .edge_hi     (edge_hi)
  );

  gcc_reach #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES)
  ) u_reach (
    .clk       (clk),
    .rst       (rst),
    .n_used    (n_used),
    .col_fire  (col_fire),
    .col_last  (last_column),
    .edge_ok   (edge_ok),
    .edge_lo   (edge_lo),
    .edge_hi   (edge_hi),
    .in_ready  (in_ready),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // output stage
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      connected     <= res.connected;
      reached_count <= res.reached_count;
      overflow      <= res.overflow;
    end
  end

endmodule

`default_nettype wire
